### design/tdt_pkg.sv
// ============================================================================
// Task dependence table package
// Field widths, stream packing and result codes shared by the table's modules.
// ============================================================================
`default_nettype none

package tdt_pkg;

    localparam int MAX_SLOTS  = 64;
    localparam int ID_W       = 6;
    localparam int DEP_W      = 64;
    localparam int KIND_W     = 3;
    localparam int COUNT_W    = 7;

    // Input tdata: slot_id, dep_pattern, padded to whole bytes.
    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 1;
    localparam int DEP_LSB    = ID_W;

    // Output tdata: result_kind, slot, occupied_count.
    localparam int M_TDATA_W  = 16;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_WAITING      = 3'd0;
    localparam kind_t KIND_READY        = 3'd1;
    localparam kind_t KIND_BECAME_READY = 3'd2;
    localparam kind_t KIND_DONE         = 3'd3;
    localparam kind_t KIND_FULL         = 3'd4;
    localparam kind_t KIND_NOT_OCCUPIED = 3'd5;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

endpackage

`default_nettype wire

### design/tdt_row_mem.sv
// ============================================================================
// Wait-row memory
// One row of wait bits per slot, single port, registered read. Rows that were
// never written since reset read as zero through per-row valid bits.
// ============================================================================
`default_nettype none

module tdt_row_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] row_valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= row_valid_reg[addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### design/tdt_free_stack.sv
// ============================================================================
// Free-slot stack memory
// Stack storage for free slot numbers, single port, registered read. An
// entry that was never pushed since reset reads as its own index.
// ============================================================================
`default_nettype none

module tdt_free_stack #(
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [ADDR_W-1:0] wr_data,
    output logic      [ADDR_W-1:0] rd_data
);

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  entry_valid_reg;
    logic [ADDR_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
            rd_addr_reg <= addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_hit_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_valid_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= entry_valid_reg[addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : rd_addr_reg;

endmodule

`default_nettype wire

### design/task_dependence_table.sv
// ============================================================================
// Task dependence table
// Slot table of waiting tasks with a free-slot stack; a remove sweeps all
// wait rows through one row-clear and zero-test unit.
// ============================================================================
//
//  Channel   Dir  Signals                               Contents
//  s_axis    in   tvalid tready tdata[71:0] tuser[0]    request transaction
//  m_axis    out  tvalid tready tdata[15:0] tlast       result transaction
//
//  An add reads the stack, then writes the row and the result.
//  A remove reads each row, then clears and tests it through the single
//  row-memory port.
//  A rejected add (table full) or remove (slot not occupied) answers at once.
//  Reset leaves all rows zero and all slots free; no clearing pass is needed.
//  A stalled result holds the sequencer; s_axis_tready is low until it is idle.
// ============================================================================
`default_nettype none

module task_dependence_table #(
    parameter int NUM_SLOTS = tdt_pkg::MAX_SLOTS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] slot_id, [69:6] dep_pattern, [71:70] zero
    input  wire logic [tdt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  wire logic [tdt_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [2:0] result_kind, [8:3] slot, [15:9] occupied_count
    output logic      [tdt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // last_result
    output logic                                m_axis_tlast
);

    import tdt_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ADD_WR   = 3'd1;
    localparam logic [2:0] ST_SCAN_RD  = 3'd2;
    localparam logic [2:0] ST_SCAN_CHK = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    logic [2:0]           state_reg,      state_next;
    logic [CNT_W-1:0]     free_count_reg, free_count_next;
    logic [NUM_SLOTS-1:0] occ_reg,        occ_next;
    logic [NUM_SLOTS-1:0] dep_reg,        dep_next;
    logic [IDX_W-1:0]     id_reg,         id_next;
    logic [IDX_W-1:0]     scan_reg,       scan_next;

    logic                 m_valid_reg;
    kind_t                m_kind_reg;
    logic [ID_W-1:0]      m_slot_reg;
    logic [COUNT_W-1:0]   m_count_reg;
    logic                 m_last_reg;

    logic                 emit;
    kind_t                emit_kind;
    logic [ID_W-1:0]      emit_slot;
    logic                 emit_last;

    logic                 out_free;
    logic                 in_accept;
    logic                 req_remove;
    logic [ID_W-1:0]      in_id;
    logic [IDX_W-1:0]     in_idx;
    logic [DEP_W-1:0]     in_dep;
    logic                 id_occupied;

    logic                 row_rd_en;
    logic                 row_wr_en;
    logic [IDX_W-1:0]     row_addr;
    logic [NUM_SLOTS-1:0] row_wr_data;
    logic [NUM_SLOTS-1:0] row_rd_data;

    logic                 stk_rd_en;
    logic                 stk_wr_en;
    logic [IDX_W-1:0]     stk_addr;
    logic [IDX_W-1:0]     stk_rd_data;

    logic [NUM_SLOTS-1:0] new_bit;
    logic [NUM_SLOTS-1:0] new_row;
    logic [NUM_SLOTS-1:0] id_bit;
    logic [NUM_SLOTS-1:0] row_now;
    logic                 became_ready;

    tdt_row_mem #(
        .DEPTH  (NUM_SLOTS),
        .WIDTH  (NUM_SLOTS),
        .ADDR_W (IDX_W)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (row_rd_en),
        .wr_en   (row_wr_en),
        .addr    (row_addr),
        .wr_data (row_wr_data),
        .rd_data (row_rd_data)
    );

    tdt_free_stack #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (IDX_W)
    ) u_free_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (stk_rd_en),
        .wr_en   (stk_wr_en),
        .addr    (stk_addr),
        .wr_data (id_next),
        .rd_data (stk_rd_data)
    );

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign req_remove  = (s_axis_tuser[0] == REQ_REMOVE);
    assign in_id       = s_axis_tdata[ID_W-1:0];
    assign in_idx      = in_id[IDX_W-1:0];
    assign in_dep      = s_axis_tdata[DEP_LSB +: DEP_W];
    assign id_occupied = (COUNT_W'(in_id) < COUNT_W'(NUM_SLOTS)) && occ_reg[in_idx];

    // Row build for an add, and the row-clear and zero-test unit shared by every step of a remove sweep.
    assign new_bit      = NUM_SLOTS'(1) << stk_rd_data;
    assign new_row      = dep_reg & occ_reg & ~new_bit;
    assign id_bit       = NUM_SLOTS'(1) << id_reg;
    assign row_now      = (scan_reg == id_reg) ? '0 : (row_rd_data & ~id_bit);
    assign became_ready = (row_rd_data != '0) && (row_now == '0) && occ_reg[scan_reg];

    always_comb
    begin
        state_next      = state_reg;
        free_count_next = free_count_reg;
        occ_next        = occ_reg;
        dep_next        = dep_reg;
        id_next         = id_reg;
        scan_next       = scan_reg;
        emit            = 1'b0;
        emit_kind       = KIND_DONE;
        emit_slot       = '0;
        emit_last       = 1'b1;
        row_rd_en       = 1'b0;
        row_wr_en       = 1'b0;
        row_addr        = scan_reg;
        row_wr_data     = row_now;
        stk_rd_en       = 1'b0;
        stk_wr_en       = 1'b0;
        stk_addr        = free_count_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!req_remove)
                    begin
                        if (free_count_reg == '0)
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_FULL;
                        end
                        else
                        begin
                            free_count_next = free_count_reg - CNT_W'(1);
                            stk_rd_en       = 1'b1;
                            stk_addr        = free_count_next[IDX_W-1:0];
                            dep_next        = in_dep[NUM_SLOTS-1:0];
                            state_next      = ST_ADD_WR;
                        end
                    end
                    else if (!id_occupied)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_NOT_OCCUPIED;
                        emit_slot = in_id;
                    end
                    else
                    begin
                        // Push the freed slot just above the current top of stack.
                        occ_next[in_idx] = 1'b0;
                        id_next          = in_idx;
                        stk_wr_en        = 1'b1;
                        free_count_next  = free_count_reg + CNT_W'(1);
                        scan_next        = '0;
                        state_next       = ST_SCAN_RD;
                    end
                end
            end

            ST_ADD_WR:
            begin
                if (out_free)
                begin
                    row_wr_en   = 1'b1;
                    row_addr    = stk_rd_data;
                    row_wr_data = new_row;
                    occ_next    = occ_reg | new_bit;
                    emit        = 1'b1;
                    emit_kind   = (new_row == '0) ? KIND_READY : KIND_WAITING;
                    emit_slot   = ID_W'(stk_rd_data);
                    state_next  = ST_IDLE;
                end
            end

            ST_SCAN_RD:
            begin
                row_rd_en  = 1'b1;
                state_next = ST_SCAN_CHK;
            end

            ST_SCAN_CHK:
            begin
                if (!became_ready || out_free)
                begin
                    row_wr_en = 1'b1;
                    if (became_ready)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_BECAME_READY;
                        emit_slot = ID_W'(scan_reg);
                        emit_last = 1'b0;
                    end
                    if (scan_reg == IDX_W'(NUM_SLOTS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        scan_next  = scan_reg + IDX_W'(1);
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_DONE;
                    emit_slot  = ID_W'(id_reg);
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_count_reg <= CNT_W'(NUM_SLOTS);
            occ_reg        <= '0;
            id_reg         <= '0;
            scan_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            occ_reg        <= occ_next;
            id_reg         <= id_next;
            scan_reg       <= scan_next;
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dep_reg <= dep_next;
        if (emit)
        begin
            m_kind_reg  <= emit_kind;
            m_slot_reg  <= emit_slot;
            m_count_reg <= COUNT_W'(NUM_SLOTS) - COUNT_W'(free_count_next);
            m_last_reg  <= emit_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_count_reg, m_slot_reg, m_kind_reg};
    assign m_axis_tlast  = m_last_reg;

    // Between requests every slot is either on the stack or occupied.
    a_slot_balance : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
            ($countones(occ_reg) + int'(free_count_reg) == NUM_SLOTS))
        else $error("occupied slots and free count disagree");

    // A free slot other than the one being freed must hold an all-zero row.
    a_free_row_zero : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN_CHK) && !occ_reg[scan_reg] && (scan_reg != id_reg))
            |-> (row_rd_data == '0))
        else $error("free slot holds wait bits");

    // The freed slot stays unoccupied for the whole sweep.
    a_freed_slot : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN_RD) || (state_reg == ST_SCAN_CHK) || (state_reg == ST_DONE))
            |-> !occ_reg[id_reg])
        else $error("freed slot occupied during sweep");

endmodule

`default_nettype wire

### tb/testbench.sv
// ============================================================================
// Task dependence table testbench
// Drives add and remove requests into the slot table and checks every result
// transaction against its listed result or an in-bench model of the wait rows and the free stack.
// A short table of directed requests comes first, then random phases that
// fill the table, drain it and mix both, with random gaps and stalls.
// ============================================================================
`timescale 1ns / 100ps

module testbench;

    import tdt_pkg::*;

    localparam int TABLE_SLOTS  = MAX_SLOTS;
    localparam int RANDOM_ITEMS = 450;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    slot;
        logic [COUNT_W-1:0] count;
        logic               last;
    } outcome_t;

    typedef struct packed {
        logic             typed;
        logic             req;
        logic [ID_W-1:0]  id;
        logic [DEP_W-1:0] dep;
        outcome_t         want;
    } request_row_t;

    typedef enum int {
        FILL_PHASE,
        DRAIN_PHASE,
        MIXED_PHASE
    } phase_kind_t;

    localparam logic [DEP_W-1:0] ALL_DEPS = {DEP_W{1'b1}};

    // Rows with typed = 1 carry their result; the others go through the model.
    localparam int DIRECTED_ROWS = 17;
    localparam request_row_t DIRECTED[DIRECTED_ROWS] = '{
        '{1'b1, REQ_REMOVE, 6'd5,  64'd0, '{KIND_NOT_OCCUPIED, 6'd5,  7'd0, 1'b1}},
        '{1'b1, REQ_REMOVE, 6'd63, ALL_DEPS, '{KIND_NOT_OCCUPIED, 6'd63, 7'd0, 1'b1}},
        '{1'b1, REQ_ADD,    6'd0,  64'd0, '{KIND_READY, 6'd63, 7'd1, 1'b1}},
        '{1'b0, REQ_ADD,    6'd63, ALL_DEPS, '0},
        '{1'b0, REQ_ADD,    6'd0,  ALL_DEPS, '0},
        '{1'b1, REQ_ADD,    6'd0,  64'h1000_0000_0000_0000,
            '{KIND_READY, 6'd60, 7'd4, 1'b1}},
        '{1'b1, REQ_ADD,    6'd0,  64'h0000_0000_FFFF_FFFF,
            '{KIND_READY, 6'd59, 7'd5, 1'b1}},
        '{1'b0, REQ_ADD,    6'd0,  64'h8000_0000_0000_0000, '0},
        '{1'b0, REQ_ADD,    6'd0,  64'h8000_0000_0000_0000, '0},
        '{1'b0, REQ_ADD,    6'd0,  64'h9000_0000_0000_0000, '0},
        '{1'b0, REQ_REMOVE, 6'd62, 64'd0, '0},
        '{1'b0, REQ_REMOVE, 6'd63, 64'd0, '0},
        '{1'b0, REQ_REMOVE, 6'd60, 64'd0, '0},
        '{1'b0, REQ_REMOVE, 6'd62, 64'd0, '0},
        '{1'b0, REQ_ADD,    6'd0,  ALL_DEPS, '0},
        '{1'b0, REQ_ADD,    6'd0,  ALL_DEPS, '0},
        '{1'b0, REQ_REMOVE, 6'd0,  ALL_DEPS, '0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    // Travels with the request so the monitor knows whether a result is typed.
    logic                 row_typed = 1'b0;
    outcome_t             row_want = '0;

    // Model state.
    logic [DEP_W-1:0]     wait_mask [TABLE_SLOTS];
    logic [ID_W-1:0]      free_slots [TABLE_SLOTS];
    int unsigned          free_total;
    logic [DEP_W-1:0]     busy_mask;

    outcome_t             step_outcomes[$];
    outcome_t             awaited_results[$];
    int unsigned          failures = 0;
    int unsigned          burst_left = 0;
    int unsigned          ready_mode = 0;
    int unsigned          mode_left = 0;

    task_dependence_table #(
        .NUM_SLOTS(TABLE_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("testbench failed");
        $finish;
    end

    function automatic void note_outcome(input kind_t kind, input logic [ID_W-1:0] slot,
                                         input logic last);
        outcome_t o;
        o.kind  = kind;
        o.slot  = slot;
        o.count = COUNT_W'($countones(busy_mask));
        o.last  = last;
        step_outcomes.insert(step_outcomes.size(), o);
    endfunction

    function automatic void clear_table();
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            wait_mask[s]  = '0;
            free_slots[s] = ID_W'(s);
        end
        free_total = TABLE_SLOTS;
        busy_mask  = '0;
    endfunction

    // Applies one request to the model and leaves its results in step_outcomes.
    function automatic void schedule_request(input logic req, input logic [ID_W-1:0] id,
                                             input logic [DEP_W-1:0] dep);
        logic [DEP_W-1:0] slot_bit;
        logic [DEP_W-1:0] prior;
        logic [ID_W-1:0]  slot;
        int unsigned      released;
        step_outcomes.delete();
        released = 0;
        if (req == REQ_ADD)
        begin
            if (free_total == 0)
            begin
                note_outcome(KIND_FULL, '0, 1'b1);
            end
            else
            begin
                free_total--;
                slot = free_slots[free_total];
                slot_bit = DEP_W'(1) << slot;
                wait_mask[slot] = dep & busy_mask & ~slot_bit;
                busy_mask |= slot_bit;
                note_outcome(wait_mask[slot] == '0 ? KIND_READY : KIND_WAITING, slot, 1'b1);
            end
        end
        else
        begin
            slot_bit = DEP_W'(1) << id;
            if (int'(id) >= TABLE_SLOTS || (busy_mask & slot_bit) == '0)
            begin
                note_outcome(KIND_NOT_OCCUPIED, id, 1'b1);
            end
            else
            begin
                busy_mask &= ~slot_bit;
                wait_mask[id] = '0;
                free_slots[free_total] = id;
                free_total++;
                for (int s = 0; s < TABLE_SLOTS; s++)
                begin
                    prior = wait_mask[s];
                    wait_mask[s] = prior & ~slot_bit;
                    if (prior != '0 && wait_mask[s] == '0 && busy_mask[s] && released < 63)
                    begin
                        note_outcome(KIND_BECAME_READY, ID_W'(s), 1'b0);
                        released++;
                    end
                end
                note_outcome(KIND_DONE, id, 1'b1);
            end
        end
    endfunction

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        outcome_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            schedule_request(s_axis_tuser[0], s_axis_tdata[ID_W-1:0],
                             s_axis_tdata[DEP_LSB +: DEP_W]);
            if (row_typed)
                awaited_results.insert(awaited_results.size(), row_want);
            else
                foreach (step_outcomes[i])
                    awaited_results.insert(awaited_results.size(), step_outcomes[i]);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual tdata %h tlast %b",
                             $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("result_kind", 32'(want.kind), 32'(m_axis_tdata[2:0]));
                compare_field("slot", 32'(want.slot), 32'(m_axis_tdata[8:3]));
                compare_field("occupied_count", 32'(want.count), 32'(m_axis_tdata[15:9]));
                compare_field("last_result", 32'(want.last), 32'(m_axis_tlast));
            end
        end
    end

    // Receiver: switches between always ready and increasingly stall-heavy modes.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 400);
        end
        else
        begin
            mode_left--;
        end
        m_axis_tready <= (ready_mode == 0) || ($urandom_range(0, ready_mode) == 0);
    end

    task automatic issue_request(input logic req, input logic [ID_W-1:0] id,
                                 input logic [DEP_W-1:0] dep, input logic typed,
                                 input outcome_t want);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[ID_W-1:0] = id;
        word[DEP_LSB +: DEP_W] = dep;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= req;
        row_typed     <= typed;
        row_want      <= want;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Sender pacing: bursts of back-to-back requests separated by random gaps.
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else if ($urandom_range(0, 5) == 0)
                gap = $urandom_range(10, 30);
            else
                gap = $urandom_range(1, 4);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic [ID_W-1:0] pick_busy_slot();
        int unsigned      start;
        logic [ID_W-1:0]  s;
        start = $urandom_range(0, TABLE_SLOTS - 1);
        for (int k = 0; k < TABLE_SLOTS; k++)
        begin
            s = ID_W'(start + k);
            if (busy_mask[s])
                return s;
        end
        return ID_W'(start);
    endfunction

    // Hub dependences let one remove release a long run of waiting tasks.
    function automatic logic [DEP_W-1:0] draw_dependences(input logic [ID_W-1:0] hub);
        logic [DEP_W-1:0] noise;
        noise = {$urandom, $urandom};
        case ($urandom_range(0, 9)) inside
            0:       return '0;
            1:       return ALL_DEPS;
            2, 3:    return noise;
            4, 5, 6: return DEP_W'(1) << hub;
            7, 8:    return busy_mask & noise & {$urandom, $urandom};
            default: return busy_mask & noise;
        endcase
    endfunction

    initial
    begin : stimulus
        phase_kind_t      phase;
        int unsigned      sent;
        int unsigned      phase_no;
        int unsigned      phase_len;
        int unsigned      add_pct;
        logic [ID_W-1:0]  hub;
        logic [ID_W-1:0]  id;
        clear_table();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
        begin
            issue_request(DIRECTED[r].req, DIRECTED[r].id, DIRECTED[r].dep,
                          DIRECTED[r].typed, DIRECTED[r].want);
            pace();
        end

        // The first phase adds well past capacity so the full case is hit.
        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase_no == 0)
                phase = FILL_PHASE;
            else
                phase = phase_kind_t'($urandom_range(0, 2));
            phase_len = (phase_no == 0) ? 80 : $urandom_range(20, 60);
            case (phase)
                FILL_PHASE:  add_pct = 85;
                DRAIN_PHASE: add_pct = 15;
                default:     add_pct = 50;
            endcase
            hub = pick_busy_slot();
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                if ($urandom_range(1, 100) <= add_pct)
                begin
                    issue_request(REQ_ADD, ID_W'($urandom), draw_dependences(hub), 1'b0, '0);
                end
                else
                begin
                    if (busy_mask == '0 || $urandom_range(0, 6) == 0)
                        id = ID_W'($urandom);
                    else
                        id = pick_busy_slot();
                    issue_request(REQ_REMOVE, id, {$urandom, $urandom}, 1'b0, '0);
                end
                if (!busy_mask[hub])
                    hub = pick_busy_slot();
                pace();
                sent++;
            end
            phase_no++;
        end
        s_axis_tvalid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (2 * TABLE_SLOTS + 16) @(posedge clk);
        if (failures == 0 && awaited_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
